// ----- hdl/olad_pkg.sv -----
package olad_pkg;

   localparam int LIST_DEPTH = 16;
   localparam int IDX_W      = $clog2(LIST_DEPTH);
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int ENTRY_CNT_W = 5;

   typedef enum logic [0:0] {
      KIND_APPEND = 1'b0,
      KIND_DELETE = 1'b1
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_APPENDED  = 2'd0,
      ST_FULL      = 2'd1,
      ST_DELETED   = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef struct packed {
      kind_type                   kind;
      logic signed [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic [ENTRY_CNT_W-1:0]     entry_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       commit;
      status_type outcome;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      kind_type kind;
      logic     found;
      logic     full;
   } dp_status_type;

endpackage

// ----- hdl/olad_datapath.sv -----
module olad_datapath
   import olad_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  cmd_type       cmd,
   output dp_status_type dp_status,
   output rsp_type       rsp_data
);

   logic signed [VALUE_W-1:0] cells_ff [LIST_DEPTH];
   logic signed [VALUE_W-1:0] cells_in [LIST_DEPTH];
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   logic signed [VALUE_W-1:0] value_ff;
   kind_type                  kind_ff;
   logic [LIST_DEPTH-1:0]     match_ff;
   logic [LIST_DEPTH-1:0]     match_in;
   logic [LIST_DEPTH-1:0]     first_hit;
   logic [LIST_DEPTH-1:0]     shift_mask;
   rsp_type                   rsp_ff;

   // every occupied cell compares against the incoming value
   always_comb begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
         match_in[i] = (CNT_W'(i) < count_ff) && (cells_ff[i] == req_data.value);
      end
   end

   // lowest set match bit, then every cell at or above it
   assign first_hit  = match_ff & ~(match_ff - 1'b1);
   assign shift_mask = ~(first_hit - 1'b1);

   always_comb begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
         cells_in[i] = cells_ff[i];
      end
      count_in = count_ff;
      if (cmd.commit) begin
         case (cmd.outcome)
            ST_APPENDED: begin
               for (int i = 0; i < LIST_DEPTH; i++) begin
                  if (CNT_W'(i) == count_ff) begin
                     cells_in[i] = value_ff;
                  end
               end
               count_in = count_ff + 1'b1;
            end
            ST_DELETED: begin
               for (int i = 0; i < LIST_DEPTH - 1; i++) begin
                  if (shift_mask[i]) begin
                     cells_in[i] = cells_ff[i+1];
                  end
               end
               count_in = count_ff - 1'b1;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < LIST_DEPTH; i++) begin
         cells_ff[i] <= cells_in[i];
      end
      if (cmd.capture) begin
         value_ff <= req_data.value;
         kind_ff  <= req_data.kind;
         match_ff <= match_in;
      end
      if (cmd.commit) begin
         rsp_ff.status      <= cmd.outcome;
         rsp_ff.entry_count <= ENTRY_CNT_W'(count_in);
      end
   end

   assign dp_status.kind  = kind_ff;
   assign dp_status.found = |match_ff;
   assign dp_status.full  = (count_ff == CNT_W'(LIST_DEPTH));
   assign rsp_data        = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(LIST_DEPTH))
      else $error("entry count above list depth");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && cmd.outcome == ST_APPENDED |=> count_ff == $past(count_ff) + 1'b1)
      else $error("append did not grow the list by one");

   a_delete_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && cmd.outcome == ST_DELETED |=> count_ff == $past(count_ff) - 1'b1)
      else $error("delete did not shrink the list by one");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !cmd.commit |=> $stable(count_ff))
      else $error("entry count moved without a commit");

endmodule

// ----- hdl/olad_ctrl.sv -----
module olad_ctrl
   import olad_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type dp_status,
   output cmd_type       cmd,
   output logic          busy,
   output logic          rsp_valid
);

   typedef enum logic [0:0] {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;

   always_comb begin
      cmd.capture = (state_ff == S_IDLE) && start;
      cmd.commit  = (state_ff == S_EXEC);
      if (dp_status.kind == KIND_APPEND) begin
         cmd.outcome = dp_status.full ? ST_FULL : ST_APPENDED;
      end else begin
         cmd.outcome = dp_status.found ? ST_DELETED : ST_NOT_FOUND;
      end
      case (state_ff)
         S_IDLE:  state_in = start ? S_EXEC : S_IDLE;
         S_EXEC:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.commit;
      end
   end

   assign busy      = (state_ff == S_EXEC);
   assign rsp_valid = rsp_valid_ff;

   a_capture_then_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == S_EXEC && !cmd.capture)
      else $error("accepted transaction did not move to execute");

   a_one_rsp_per_commit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd.commit) && !cmd.commit)
      else $error("response strobe without a preceding commit");

endmodule

// ----- hdl/ordered_list_append_delete_top.sv -----
// channel   ports                        direction  handshake
// request   start, busy, req_data        in         taken when start && !busy
// response  rsp_valid, rsp_data          out        one-cycle strobe, no stall
//
// in each transaction the accept edge compares the value against
// all occupied cells in parallel, the next edge commits the append or the
// one-step shift and launches the response, so busy is high for one cycle.
// a new transaction can start only once busy is low; the controller sets that.
// reset clears the entry count and the controller; cells are never read until written.
// the receiver cannot stall, so rsp_valid is high for exactly one cycle.
module ordered_list_append_delete_top
   import olad_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   cmd_type       cmd;
   dp_status_type dp_status;

   olad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .dp_status (dp_status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   olad_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .dp_status (dp_status),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- bench/ordered_list_checker.sv -----
module ordered_list_checker
   import olad_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      errors,
   output int      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow of the list contents, head at index 0
   logic signed [VALUE_W-1:0] held_values[$];
   rsp_type                   due_responses[$];
   int                        error_total = 0;

   function automatic rsp_type apply_request(input req_type r);
      rsp_type res;
      int      hit;
      hit = -1;
      if (r.kind == KIND_APPEND) begin
         if (held_values.size() >= LIST_DEPTH) begin
            res.status = ST_FULL;
         end else begin
            held_values.push_back(r.value);
            res.status = ST_APPENDED;
         end
      end else begin
         // first match from the head wins
         foreach (held_values[i]) begin
            if (hit < 0 && held_values[i] == r.value) hit = i;
         end
         if (hit < 0) begin
            res.status = ST_NOT_FOUND;
         end else begin
            held_values.delete(hit);
            res.status = ST_DELETED;
         end
      end
      res.entry_count = ENTRY_CNT_W'(held_values.size());
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         held_values.delete();
         due_responses.delete();
      end else begin
         if (start && !busy) due_responses.push_back(apply_request(req_data));
         if (rsp_valid) begin
            if (due_responses.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual status %0d count %0d",
                        $time, rsp_data.status, rsp_data.entry_count);
               error_total++;
            end else begin
               want = due_responses.pop_front();
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_data.status);
                  error_total++;
               end
               if (rsp_data.entry_count !== want.entry_count) begin
                  $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                           $time, want.entry_count, rsp_data.entry_count);
                  error_total++;
               end
            end
         end
      end
      errors  <= error_total;
      pending <= due_responses.size();
   end

endmodule

// ----- bench/tb_ordered_list_append_delete_top.sv -----
module tb_ordered_list_append_delete_top;
   timeunit 1ns;
   timeprecision 1ps;

   import olad_pkg::*;

   localparam int RANDOM_ITEMS = 1000;
   localparam int QUIET_TAIL   = 150;
   localparam int STALL_LIMIT  = 400;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      check_errors;
   int      check_pending;

   // values appended lately, used to aim deletes at real entries
   logic signed [VALUE_W-1:0] recent_values[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ordered_list_append_delete_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   ordered_list_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .errors    (check_errors),
      .pending   (check_pending)
   );

   // called at a falling edge; returns at the falling edge after the transaction
   task automatic send(input kind_type kind, input logic signed [VALUE_W-1:0] value);
      start    <= 1'b1;
      req_data <= '{kind: kind, value: value};
      do @(posedge clock); while (busy);
      if (kind == KIND_APPEND) begin
         recent_values.push_back(value);
         if (recent_values.size() > 32) void'(recent_values.pop_front());
      end
      @(negedge clock);
   endtask

   task automatic idle(input int cycles);
      start    <= 1'b0;
      req_data <= '{kind: kind_type'($urandom_range(1)), value: $urandom};
      repeat (cycles) @(negedge clock);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value(input bit for_delete);
      int sel;
      int near_zero;
      sel = $urandom_range(99);
      if (for_delete && recent_values.size() > 0 && sel < 60)
         return recent_values[$urandom_range(recent_values.size() - 1)];
      if (sel < 70) begin
         // narrow range so duplicates are common
         near_zero = int'($urandom_range(8)) - 4;
         return near_zero;
      end
      if (sel < 92) return $urandom;
      case ($urandom_range(3))
         0:       return 32'sh8000_0000;
         1:       return 32'sh7fff_ffff;
         2:       return -32'sd1;
         default: return 32'sd0;
      endcase
   endfunction

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("tb_ordered_list_append_delete_top: done, errors");
      $finish;
   end

   initial begin : stimulus
      int       seg_left;
      int       append_pct;
      int       gap_pct;
      kind_type kind;
      logic signed [VALUE_W-1:0] value;

      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      seg_left = 0;
      append_pct = 50;
      gap_pct = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // delete from an empty list
      send(KIND_DELETE, 32'sd0);
      send(KIND_APPEND, 32'sh8000_0000);
      send(KIND_APPEND, 32'sh7fff_ffff);
      send(KIND_APPEND, 32'sd5);
      send(KIND_APPEND, -32'sd1);
      send(KIND_APPEND, 32'sd5);
      // head removal, then duplicates: first match goes, then the tail one
      send(KIND_DELETE, 32'sh8000_0000);
      send(KIND_DELETE, 32'sd5);
      idle(3);
      send(KIND_DELETE, 32'sd5);
      // fill to capacity, then overflow and a miss on a full list
      repeat (LIST_DEPTH - 2) send(KIND_APPEND, $urandom);
      send(KIND_APPEND, 32'sd7);
      send(KIND_DELETE, 32'sh0123_4567);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (seg_left == 0) begin
            // pick fill-heavy or drain-heavy stretches at random
            seg_left   = $urandom_range(60, 15);
            append_pct = ($urandom_range(1) == 1) ? 75 : 30;
            gap_pct    = ($urandom_range(2) == 0) ? 0 : 35;
         end
         seg_left--;
         kind  = ($urandom_range(99) < append_pct) ? KIND_APPEND : KIND_DELETE;
         value = pick_value(kind == KIND_DELETE);
         send(kind, value);
         if (n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(99) < gap_pct)
            idle($urandom_range(12, 1));
      end
      start <= 1'b0;

      while (check_pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (check_errors == 0 && check_pending == 0)
         $display("tb_ordered_list_append_delete_top: done, clean");
      else
         $display("tb_ordered_list_append_delete_top: done, errors");
      $finish;
   end

endmodule
